### design/blr_pkg.sv
// Shared types for the line rasterizer: controller states and the control/status bundles.
package blr_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_WALK
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture a request: order endpoints, apply the mirror
        logic setup;   // pick the major axis, compute error increments
        logic emit;    // present the current pixel and advance the walk
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;  // output register can take a pixel this cycle
        logic at_end;    // current pixel is the last one of the line
    } dp_status_t;

endpackage

### design/blr_ctrl.sv
// Controller state machine for the line rasterizer.
module blr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  blr_pkg::dp_status_t status,
    output blr_pkg::dp_cmd_t    cmd
);
    import blr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.at_end)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### design/blr_datapath.sv
// Datapath for the line rasterizer: endpoint ordering, octant setup, error walk, output register.
module blr_datapath #(
    parameter int COORD_BITS = 6
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  blr_pkg::dp_cmd_t          cmd,
    output blr_pkg::dp_status_t       status,
    input  logic [4*COORD_BITS-1:0]   in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [2*COORD_BITS-1:0]   out_data,
    output logic                      out_last
);
    import blr_pkg::*;

    localparam int N = COORD_BITS;
    localparam int P = COORD_BITS + 1;   // walk-frame position, holds mirrored values
    localparam int E = COORD_BITS + 3;   // error term and increments

    // ---------------- request capture ----------------
    logic signed [N-1:0] sx, sy, ex, ey;
    logic signed [N-1:0] ox0, oy0, ox1, oy1;
    logic                swap_ends;
    logic                mirror_now;
    logic signed [P-1:0] oy0_w, oy1_w;

    assign sx = in_data[N-1:0];
    assign sy = in_data[2*N-1:N];
    assign ex = in_data[3*N-1:2*N];
    assign ey = in_data[4*N-1:3*N];

    assign swap_ends  = ex < sx;
    assign ox0        = swap_ends ? ex : sx;
    assign oy0        = swap_ends ? ey : sy;
    assign ox1        = swap_ends ? sx : ex;
    assign oy1        = swap_ends ? sy : ey;
    assign mirror_now = oy1 < oy0;
    assign oy0_w      = P'(oy0);
    assign oy1_w      = P'(oy1);

    logic signed [P-1:0] lo_x_reg, lo_y_reg, hi_x_reg, hi_y_reg;
    logic                mirror_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lo_x_reg <= P'(ox0);
            hi_x_reg <= P'(ox1);
            lo_y_reg <= mirror_now ? -oy0_w : oy0_w;
            hi_y_reg <= mirror_now ? -oy1_w : oy1_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            mirror_reg <= mirror_now;
        end
    end

    // ---------------- octant setup ----------------
    logic signed [E-1:0] dx_w, dy_w, dmaj, dmin;
    logic                exch_now;

    assign dx_w     = E'(hi_x_reg) - E'(lo_x_reg);
    assign dy_w     = E'(hi_y_reg) - E'(lo_y_reg);
    assign exch_now = dy_w > dx_w;
    assign dmaj     = exch_now ? dy_w : dx_w;
    assign dmin     = exch_now ? dx_w : dy_w;

    logic signed [P-1:0] major_pos_reg, minor_pos_reg, major_end_reg;
    logic signed [E-1:0] error_term_reg, step_diag_reg, step_straight_reg;
    logic                axes_exch_reg;
    logic                at_end;

    assign at_end = major_pos_reg >= major_end_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            major_pos_reg     <= exch_now ? lo_y_reg : lo_x_reg;
            minor_pos_reg     <= exch_now ? lo_x_reg : lo_y_reg;
            major_end_reg     <= exch_now ? hi_y_reg : hi_x_reg;
            step_diag_reg     <= (dmin - dmaj) <<< 1;
            step_straight_reg <= dmin <<< 1;
            error_term_reg    <= (dmin <<< 1) - dmaj;
        end
        else if (cmd.emit && !at_end)
        begin
            // a tie on zero takes the diagonal step
            if (error_term_reg >= 0)
            begin
                error_term_reg <= error_term_reg + step_diag_reg;
                minor_pos_reg  <= minor_pos_reg + P'(1);
            end
            else
            begin
                error_term_reg <= error_term_reg + step_straight_reg;
            end
            major_pos_reg <= major_pos_reg + P'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axes_exch_reg <= 1'b0;
        end
        else if (cmd.setup)
        begin
            axes_exch_reg <= exch_now;
        end
    end

    // ---------------- map back and output register ----------------
    logic signed [P-1:0] pa, pb, pb_m;

    assign pa   = axes_exch_reg ? minor_pos_reg : major_pos_reg;
    assign pb   = axes_exch_reg ? major_pos_reg : minor_pos_reg;
    assign pb_m = mirror_reg ? -pb : pb;

    logic                out_valid_reg;
    logic [N-1:0]        out_x_reg, out_y_reg;
    logic                out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_x_reg    <= pa[N-1:0];
            out_y_reg    <= pb_m[N-1:0];
            out_last_reg <= at_end;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_data        = {out_y_reg, out_x_reg};
    assign out_last        = out_last_reg;
    assign status.out_free = !out_valid_reg || out_ready;
    assign status.at_end   = at_end;

endmodule

### design/bresenham_line_rasterizer.sv
// Top level of the Bresenham line rasterizer: stream ports, controller and datapath.
//
// Usage:
//   One request on the s_axis channel carries a line: start and end points, each
//   coordinate a COORD_BITS-bit two's complement value. The block answers on the
//   m_axis channel with every pixel of the line in drawing order, left to right
//   (start to end for vertical lines), one pixel per transfer, with tlast set on
//   the final pixel. A line with equal endpoints gives a single pixel with tlast.
//   Sequence: the idle state takes a request, the setup state computes the error
//   increments, then the walk produces one pixel per cycle while the output
//   register can take one; a line has L pixels (L up to 2^COORD_BITS), with one
//   error update for each step to the next pixel. The first pixel reaches m_axis
//   through the setup state and the output register after the request is taken.
//   s_axis_tready is high only while no line is being walked; the next request
//   can be accepted while the last pixel still waits in the output register.
//   When m_axis_tready is low the walk holds and no pixel is lost or repeated.
//   Reset (rst_n low, asynchronous) returns the block to idle and drops
//   m_axis_tvalid.
module bresenham_line_rasterizer #(
    parameter int COORD_BITS = 6
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // start_x, start_y, end_x, end_y, zero pad to bytes
    input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // pixel_x, pixel_y, zero pad to bytes
    output logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic m_axis_tlast
);
    import blr_pkg::*;

    localparam int IN_BITS  = 4 * COORD_BITS;
    localparam int OUT_BITS = 2 * COORD_BITS;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    dp_cmd_t             cmd;
    dp_status_t          status;
    logic [OUT_BITS-1:0] pix_data;

    blr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    blr_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_axis_tdata[IN_BITS-1:0]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (pix_data),
        .out_last  (m_axis_tlast)
    );

    generate
        if (OUT_W > OUT_BITS)
        begin : g_pad
            assign m_axis_tdata = {{(OUT_W - OUT_BITS){1'b0}}, pix_data};
        end
        else
        begin : g_nopad
            assign m_axis_tdata = pix_data;
        end
    endgenerate

endmodule

### tb/tb_bresenham_line_rasterizer.sv
// Self-checking testbench for the Bresenham line rasterizer: line requests in, pixels checked.
module tb_bresenham_line_rasterizer;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS = 6;
    localparam int MAX_PIXELS = 1 << COORD_BITS;
    localparam int IN_BITS    = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int MAX_ERR_LINES = 20;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
    } line_req_t;

    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        logic   last_pixel;
    } pixel_t;

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [IN_BITS-1:0]  s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OUT_BITS-1:0] m_axis_tdata;
    logic                m_axis_tlast;

    pixel_t pending_pixels[$];
    int     error_count;
    int     send_idle_pct;
    int     recv_idle_pct;

    bresenham_line_rasterizer #(
        .COORD_BITS(COORD_BITS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_ERR_LINES)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Queue one expected pixel, undoing the axis exchange first, then the mirror.
    function automatic void push_pixel(input int major, input int minor,
                                       input bit swap_xy, input bit flip_y, input bit last);
        pixel_t p;
        int     px;
        int     py;
        px = major;
        py = minor;
        if (swap_xy)
        begin
            px = minor;
            py = major;
        end
        if (flip_y)
            py = -py;
        p.pixel_x    = coord_t'(px);
        p.pixel_y    = coord_t'(py);
        p.last_pixel = last;
        pending_pixels.push_back(p);
    endfunction

    // Rasterize one line request into the queue of expected pixels.
    function automatic void predict_line(input line_req_t req);
        int ax;
        int ay;
        int bx;
        int by;
        int t;
        int d_major;
        int d_minor;
        int err;
        int major;
        int minor;
        int count;
        bit flip_y;
        bit swap_xy;
        ax = $signed(req.start_x);
        ay = $signed(req.start_y);
        bx = $signed(req.end_x);
        by = $signed(req.end_y);
        if (bx < ax)
        begin
            t = ax; ax = bx; bx = t;
            t = ay; ay = by; by = t;
        end
        flip_y = (by - ay) < 0;
        if (flip_y)
        begin
            ay = -ay;
            by = -by;
        end
        swap_xy = (by - ay) > (bx - ax);
        if (swap_xy)
        begin
            t = ax; ax = ay; ay = t;
            t = bx; bx = by; by = t;
        end
        d_major = bx - ax;
        d_minor = by - ay;
        err     = 2 * d_minor - d_major;
        major   = ax;
        minor   = ay;
        push_pixel(major, minor, swap_xy, flip_y, major >= bx);
        count = 1;
        while (major < bx && count < MAX_PIXELS)
        begin
            // a zero error term takes the diagonal step
            if (err >= 0)
            begin
                err += 2 * (d_minor - d_major);
                minor++;
            end
            else
                err += 2 * d_minor;
            major++;
            push_pixel(major, minor, swap_xy, flip_y, major >= bx);
            count++;
        end
    endfunction

    function automatic line_req_t make_line(input int sx, input int sy, input int ex, input int ey);
        line_req_t r;
        r.start_x = coord_t'(sx);
        r.start_y = coord_t'(sy);
        r.end_x   = coord_t'(ex);
        r.end_y   = coord_t'(ey);
        return r;
    endfunction

    function automatic int edge_coord();
        case ($urandom_range(3))
            0:       return -(MAX_PIXELS / 2);
            1:       return MAX_PIXELS / 2 - 1;
            2:       return -1;
            default: return 0;
        endcase
    endfunction

    // Sender side: random gap, then hold the request until it is taken.
    task automatic send_line(input line_req_t req);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= IN_BITS'($urandom);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {req.end_y, req.end_x, req.start_y, req.start_x};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_line(req);
    endtask

    task automatic send_xy(input int sx, input int sy, input int ex, input int ey);
        send_line(make_line(sx, sy, ex, ey));
    endtask

    task automatic test_single_pixel();
        send_xy(0, 0, 0, 0);
        send_xy(-32, -32, -32, -32);
        send_xy(31, 31, 31, 31);
    endtask

    task automatic test_axis_lines();
        send_xy(-32, 5, 31, 5);
        send_xy(10, -3, -10, -3);
        send_xy(4, -32, 4, 31);
        // same x, falling y: mirrored, drawn from start to end
        send_xy(-7, 20, -7, -20);
    endtask

    task automatic test_octants();
        send_xy(0, 0, 9, 4);
        send_xy(0, 0, 4, 9);
        send_xy(0, 0, -4, 9);
        send_xy(0, 0, -9, 4);
        send_xy(0, 0, -9, -4);
        send_xy(0, 0, -4, -9);
        send_xy(0, 0, 4, -9);
        send_xy(0, 0, 9, -4);
        // error term starts at zero
        send_xy(0, 0, 4, 2);
        send_xy(-32, -32, 31, 31);
        send_xy(-32, 31, 31, -32);
        send_xy(31, -32, -32, 31);
    endtask

    task automatic test_random_lines(input int count);
        int sx;
        int sy;
        int ex;
        int ey;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(7))
                0, 1:
                begin
                    // short lines keep the run fast
                    sx = int'($urandom_range(55)) - 28;
                    sy = int'($urandom_range(55)) - 28;
                    ex = sx + int'($urandom_range(8)) - 4;
                    ey = sy + int'($urandom_range(8)) - 4;
                    send_xy(sx, sy, ex, ey);
                end
                2:
                    send_xy(edge_coord(), edge_coord(), edge_coord(), edge_coord());
                default:
                    send_line(line_req_t'({$urandom, $urandom}));
            endcase
        end
    endtask

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_pixels
        pixel_t want;
        coord_t got_x;
        coord_t got_y;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_x = m_axis_tdata[COORD_BITS-1:0];
            got_y = m_axis_tdata[2*COORD_BITS-1:COORD_BITS];
            if (pending_pixels.size() == 0)
                report_error($sformatf("unexpected pixel (%0d,%0d) last=%0b",
                                       $signed(got_x), $signed(got_y), m_axis_tlast));
            else
            begin
                want = pending_pixels.pop_front();
                if (got_x !== want.pixel_x)
                    report_error($sformatf("pixel_x got %0d, expected %0d",
                                           $signed(got_x), $signed(want.pixel_x)));
                if (got_y !== want.pixel_y)
                    report_error($sformatf("pixel_y got %0d, expected %0d",
                                           $signed(got_y), $signed(want.pixel_y)));
                if (m_axis_tlast !== want.last_pixel)
                    report_error($sformatf("last_pixel got %0b, expected %0b at (%0d,%0d)",
                                           m_axis_tlast, want.last_pixel,
                                           $signed(want.pixel_x), $signed(want.pixel_y)));
            end
        end
    end

    initial
    begin
        int waited;
        error_count   = 0;
        send_idle_pct = 22;
        recv_idle_pct = 50;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_single_pixel();
        test_axis_lines();
        test_octants();
        test_random_lines(84);

        send_idle_pct = 50;
        recv_idle_pct = 22;
        test_random_lines(83);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_lines(83);

        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        waited = 0;
        while (pending_pixels.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_pixels.size() != 0)
            report_error($sformatf("%0d expected pixels never arrived", pending_pixels.size()));
        repeat (80) @(posedge clk);

        if (error_count == 0)
            $display("tb_bresenham_line_rasterizer OK");
        else
            $display("tb_bresenham_line_rasterizer NOT OK");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("tb_bresenham_line_rasterizer NOT OK");
        $finish;
    end

endmodule
